// ===== rtl/core/char_display_command_buffer_defines.svh =====
// Assertion macros shared by the display command buffer RTL.
`ifndef CHAR_DISPLAY_COMMAND_BUFFER_DEFINES_SVH
`define CHAR_DISPLAY_COMMAND_BUFFER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Plain property, checked outside reset
`define CDCB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset
`define CDCB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define CDCB_ASSERT(lbl, clk, rst_n, prop, msg)
`define CDCB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/cdcb_pkg.sv =====
// Types, codes and helper functions of the display command buffer.
package cdcb_pkg;

	localparam int LINE_CHARS_DEF = 20;
	localparam int BOOT_IDX_W     = 7;
	localparam logic [7:0] LINE1_ADDR = 8'd40;

	// Host control codes
	localparam logic [7:0] CODE_CLR_ALL = 8'h10;
	localparam logic [7:0] CODE_CR      = 8'h11;
	localparam logic [7:0] CODE_LF      = 8'h12;
	localparam logic [7:0] CODE_CRLF    = 8'h13;
	localparam logic [7:0] CODE_BEEP    = 8'h14;
	localparam logic [7:0] CODE_CLR0    = 8'h15;
	localparam logic [7:0] CODE_CLR1    = 8'h16;
	localparam logic [7:0] CODE_DIRECT  = 8'h1D;
	localparam logic [7:0] CODE_CURSOR  = 8'h1E;
	localparam logic [7:0] CODE_SHOW    = 8'h1F;

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_CURSOR = 2'd1,
		ACT_CHAR   = 2'd2,
		ACT_BEEP   = 2'd3
	} act_t;

	typedef enum logic [3:0] {
		K_ORD, K_CLR_ALL, K_CR, K_LF, K_CRLF, K_BEEP,
		K_CLR0, K_CLR1, K_DIRECT, K_CURSOR, K_SHOW
	} kind_t;

	typedef enum logic [2:0] {
		POS_HOLD, POS_ZERO, POS_LINE1, POS_CR, POS_DOWN, POS_STORE
	} pos_op_t;

	typedef enum logic [1:0] {
		IDX_HOLD, IDX_ZERO, IDX_LINE1, IDX_INC
	} idx_op_t;

	typedef enum logic [1:0] {
		VAL_ZERO, VAL_BYTE, VAL_RD, VAL_LINE1
	} val_sel_t;

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_LF_RD, S_LF_WR, S_SH_CLR,
		S_SH_C0, S_SH_RD, S_SH_CHK, S_SH_C1, S_FLUSH
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic     take;
		pos_op_t  pos_op;
		idx_op_t  idx_op;
		logic     rd_en;
		logic     rd_line1_ofs;
		logic     wr_store;
		logic     wr_copy;
		logic     clr_line0;
		logic     clr_line1;
		logic     set_cursor;
		logic     set_direct;
		logic     clr_cursor;
		logic     clr_direct;
		logic     emit;
		act_t     emit_act;
		val_sel_t emit_val;
		logic     flush;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		kind_t kind;
		logic  cursor_pending;
		logic  direct_pending;
		logic  pos_hi;
		logic  idx_hi;
		logic  idx_end;
		logic  rd_zero;
		logic  pend_v;
		logic  can_emit;
		logic  out_free;
	} status_t;

	function automatic kind_t classify(input logic [7:0] b);
		kind_t k;
		case (b)
			CODE_CLR_ALL: k = K_CLR_ALL;
			CODE_CR:      k = K_CR;
			CODE_LF:      k = K_LF;
			CODE_CRLF:    k = K_CRLF;
			CODE_BEEP:    k = K_BEEP;
			CODE_CLR0:    k = K_CLR0;
			CODE_CLR1:    k = K_CLR1;
			CODE_DIRECT:  k = K_DIRECT;
			CODE_CURSOR:  k = K_CURSOR;
			CODE_SHOW:    k = K_SHOW;
			default:      k = K_ORD;
		endcase
		return k;
	endfunction

	// Power-up banner "Waiting for data.", zero beyond it
	function automatic logic [7:0] boot_char(input logic [BOOT_IDX_W-1:0] i);
		logic [7:0] c;
		case (i)
			7'd0:    c = 8'h57;
			7'd1:    c = 8'h61;
			7'd2:    c = 8'h69;
			7'd3:    c = 8'h74;
			7'd4:    c = 8'h69;
			7'd5:    c = 8'h6E;
			7'd6:    c = 8'h67;
			7'd7:    c = 8'h20;
			7'd8:    c = 8'h66;
			7'd9:    c = 8'h6F;
			7'd10:   c = 8'h72;
			7'd11:   c = 8'h20;
			7'd12:   c = 8'h64;
			7'd13:   c = 8'h61;
			7'd14:   c = 8'h74;
			7'd15:   c = 8'h61;
			7'd16:   c = 8'h2E;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/cdcb_datapath.sv =====
// Datapath: line store, write position, prefix flags and result registers.
`include "char_display_command_buffer_defines.svh"

module cdcb_datapath #(
	parameter int LINE_CHARS = cdcb_pkg::LINE_CHARS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        host_byte,
	input  cdcb_pkg::cmd_t    cmd,
	output cdcb_pkg::status_t status,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        action,
	output logic [7:0]        value,
	output logic              last
);
	import cdcb_pkg::*;

	localparam int STORE_LEN = 2 * LINE_CHARS;
	localparam int AW        = $clog2(STORE_LEN);
	localparam logic [AW-1:0] LINE1_POS = AW'(LINE_CHARS);
	localparam logic [AW-1:0] LINE0_END = AW'(LINE_CHARS - 1);
	localparam logic [AW-1:0] LAST_POS  = AW'(STORE_LEN - 1);
	localparam logic [STORE_LEN-1:0] LINE0_MASK = {{LINE_CHARS{1'b0}}, {LINE_CHARS{1'b1}}};
	localparam logic [STORE_LEN-1:0] LINE1_MASK = ~LINE0_MASK;

	logic [7:0]           byte_q;
	logic [AW-1:0]        pos_q;
	logic [AW-1:0]        idx_q;
	logic                 cursor_q;
	logic                 direct_q;
	logic [STORE_LEN-1:0] valid_q;
	logic [STORE_LEN-1:0] boot_q;
	logic [7:0]           mem_q [STORE_LEN];
	logic [7:0]           rd_data_q;
	logic                 rd_valid_q;
	logic                 rd_boot_q;
	logic [7:0]           rd_bchar_q;
	logic                 pend_v_q;
	act_t                 pend_act_q;
	logic [7:0]           pend_val_q;
	logic                 out_valid_q;
	act_t                 out_act_q;
	logic [7:0]           out_val_q;
	logic                 out_last_q;

	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        wr_addr;
	logic [7:0]           wr_data;
	logic                 wr_en;
	logic [7:0]           rd_eff;
	logic [7:0]           emit_data;
	logic [STORE_LEN-1:0] clr_mask;
	logic [STORE_LEN-1:0] set_mask;
	logic                 out_free;
	logic                 load_out;

	// Address and data selection
	assign rd_addr = cmd.rd_line1_ofs ? (idx_q + LINE1_POS) : idx_q;
	assign wr_addr = cmd.wr_copy ? idx_q : pos_q;
	assign wr_data = cmd.wr_copy ? rd_eff : byte_q;
	assign wr_en   = cmd.wr_store | cmd.wr_copy;

	// Entry never written since reset or clear reads as banner or zero
	assign rd_eff = rd_valid_q ? rd_data_q : (rd_boot_q ? rd_bchar_q : 8'd0);

	assign clr_mask = (cmd.clr_line0 ? LINE0_MASK : '0) | (cmd.clr_line1 ? LINE1_MASK : '0);
	assign set_mask = wr_en ? (STORE_LEN'(1) << wr_addr) : '0;

	always_comb begin
		case (cmd.emit_val)
			VAL_ZERO:  emit_data = 8'd0;
			VAL_BYTE:  emit_data = byte_q;
			VAL_RD:    emit_data = rd_eff;
			VAL_LINE1: emit_data = LINE1_ADDR;
			default:   emit_data = 8'd0;
		endcase
	end

	// Line store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q  <= mem_q[rd_addr];
			rd_valid_q <= valid_q[rd_addr];
			rd_boot_q  <= boot_q[rd_addr];
			rd_bchar_q <= boot_char(BOOT_IDX_W'(rd_addr));
		end
	end

	// Input byte capture
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			byte_q <= host_byte;
		end
	end

	// Entry flags, position, sweep index, prefixes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			boot_q   <= '1;
			pos_q    <= '0;
			idx_q    <= '0;
			cursor_q <= 1'b0;
			direct_q <= 1'b0;
		end else begin
			valid_q <= (valid_q & ~clr_mask) | set_mask;
			boot_q  <= boot_q & ~clr_mask;
			case (cmd.pos_op)
				POS_HOLD:  pos_q <= pos_q;
				POS_ZERO:  pos_q <= '0;
				POS_LINE1: pos_q <= LINE1_POS;
				POS_CR:    pos_q <= (pos_q >= LINE1_POS) ? LINE1_POS : '0;
				POS_DOWN:  pos_q <= pos_q + LINE1_POS;
				POS_STORE: pos_q <= (pos_q == LAST_POS) ? LINE1_POS : pos_q + AW'(1);
				default:   pos_q <= pos_q;
			endcase
			case (cmd.idx_op)
				IDX_HOLD:  idx_q <= idx_q;
				IDX_ZERO:  idx_q <= '0;
				IDX_LINE1: idx_q <= LINE1_POS;
				IDX_INC:   idx_q <= idx_q + AW'(1);
				default:   idx_q <= idx_q;
			endcase
			if (cmd.set_cursor) cursor_q <= 1'b1;
			else if (cmd.clr_cursor) cursor_q <= 1'b0;
			if (cmd.set_direct) direct_q <= 1'b1;
			else if (cmd.clr_direct) direct_q <= 1'b0;
		end
	end

	// One result is held back so the final one can be marked last
	assign out_free = !out_valid_q || out_ready;
	assign load_out = (cmd.emit && pend_v_q) || cmd.flush;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) pend_v_q <= 1'b1;
			else if (cmd.flush) pend_v_q <= 1'b0;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pend_act_q <= cmd.emit_act;
			pend_val_q <= emit_data;
		end
		if (load_out) begin
			out_act_q  <= pend_act_q;
			out_val_q  <= pend_val_q;
			out_last_q <= cmd.flush;
		end
	end

	// Status to the controller
	assign status.kind           = classify(byte_q);
	assign status.cursor_pending = cursor_q;
	assign status.direct_pending = direct_q;
	assign status.pos_hi         = pos_q >= LINE1_POS;
	assign status.idx_hi         = idx_q >= LINE1_POS;
	assign status.idx_end        = (idx_q == LINE0_END) || (idx_q == LAST_POS);
	assign status.rd_zero        = rd_eff == 8'd0;
	assign status.pend_v         = pend_v_q;
	assign status.can_emit       = !pend_v_q || out_free;
	assign status.out_free       = out_free;

	assign out_valid = out_valid_q;
	assign action    = out_act_q;
	assign value     = out_val_q;
	assign last      = out_last_q;

	`CDCB_ASSERT(a_pos_range, clk, arst_n, pos_q <= LAST_POS, "write position past store end")
	`CDCB_ASSERT_IMP(a_flush_pend, clk, arst_n, cmd.flush, pend_v_q && out_free, "flush without held result or free slot")
	`CDCB_ASSERT_IMP(a_emit_room, clk, arst_n, cmd.emit, !pend_v_q || out_free, "result emitted while output blocked")

endmodule

// ===== rtl/core/cdcb_ctrl.sv =====
// Controller state machine: decodes host bytes and sequences scroll and redraw.
`include "char_display_command_buffer_defines.svh"

module cdcb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cdcb_pkg::status_t status,
	output cdcb_pkg::cmd_t    cmd
);
	import cdcb_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				case (status.kind)
					K_LF, K_CRLF: state_d = status.pos_hi ? S_LF_RD : S_IDLE;
					K_BEEP:       state_d = S_FLUSH;
					K_SHOW:       state_d = S_SH_CLR;
					K_ORD: begin
						if (status.cursor_pending || status.direct_pending) state_d = S_FLUSH;
						else state_d = S_IDLE;
					end
					default:      state_d = S_IDLE;
				endcase
			end
			S_LF_RD: state_d = S_LF_WR;
			S_LF_WR: state_d = status.idx_end ? S_IDLE : S_LF_RD;
			S_SH_CLR: begin
				if (status.can_emit) state_d = S_SH_C0;
			end
			S_SH_C0: begin
				if (status.can_emit) state_d = S_SH_RD;
			end
			S_SH_RD: state_d = S_SH_CHK;
			S_SH_CHK: begin
				if (status.rd_zero || (status.can_emit && status.idx_end)) begin
					state_d = status.idx_hi ? S_FLUSH : S_SH_C1;
				end else if (status.can_emit) begin
					state_d = S_SH_RD;
				end
			end
			S_SH_C1: begin
				if (status.can_emit) state_d = S_SH_RD;
			end
			S_FLUSH: begin
				if (status.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			S_EXEC: begin
				case (status.kind)
					K_CLR_ALL: begin
						cmd.clr_line0 = 1'b1;
						cmd.clr_line1 = 1'b1;
						cmd.pos_op    = POS_ZERO;
					end
					K_CR: cmd.pos_op = POS_CR;
					K_LF: begin
						if (status.pos_hi) cmd.idx_op = IDX_ZERO;
						else cmd.pos_op = POS_DOWN;
					end
					K_CRLF: begin
						cmd.pos_op = POS_LINE1;
						if (status.pos_hi) cmd.idx_op = IDX_ZERO;
					end
					K_BEEP: begin
						cmd.emit     = 1'b1;
						cmd.emit_act = ACT_BEEP;
						cmd.emit_val = VAL_ZERO;
					end
					K_CLR0: begin
						cmd.clr_line0 = 1'b1;
						cmd.pos_op    = POS_ZERO;
					end
					K_CLR1: begin
						cmd.clr_line1 = 1'b1;
						cmd.pos_op    = POS_LINE1;
					end
					K_DIRECT: cmd.set_direct = 1'b1;
					K_CURSOR: cmd.set_cursor = 1'b1;
					K_ORD: begin
						if (status.cursor_pending) begin
							cmd.emit       = 1'b1;
							cmd.emit_act   = ACT_CURSOR;
							cmd.emit_val   = VAL_BYTE;
							cmd.clr_cursor = 1'b1;
						end else if (status.direct_pending) begin
							cmd.emit       = 1'b1;
							cmd.emit_act   = ACT_CHAR;
							cmd.emit_val   = VAL_BYTE;
							cmd.clr_direct = 1'b1;
						end else begin
							cmd.wr_store = 1'b1;
							cmd.pos_op   = POS_STORE;
						end
					end
					default: ;
				endcase
			end
			// Scroll: copy line 1 into line 0 one entry at a time
			S_LF_RD: begin
				cmd.rd_en        = 1'b1;
				cmd.rd_line1_ofs = 1'b1;
			end
			S_LF_WR: begin
				cmd.wr_copy = 1'b1;
				if (status.idx_end) cmd.clr_line1 = 1'b1;
				else cmd.idx_op = IDX_INC;
			end
			// Redraw
			S_SH_CLR: begin
				cmd.emit     = status.can_emit;
				cmd.emit_act = ACT_CLEAR;
				cmd.emit_val = VAL_ZERO;
			end
			S_SH_C0: begin
				cmd.emit     = status.can_emit;
				cmd.emit_act = ACT_CURSOR;
				cmd.emit_val = VAL_ZERO;
				if (status.can_emit) cmd.idx_op = IDX_ZERO;
			end
			S_SH_RD: cmd.rd_en = 1'b1;
			S_SH_CHK: begin
				if (!status.rd_zero && status.can_emit) begin
					cmd.emit     = 1'b1;
					cmd.emit_act = ACT_CHAR;
					cmd.emit_val = VAL_RD;
					if (!status.idx_end) cmd.idx_op = IDX_INC;
				end
			end
			S_SH_C1: begin
				cmd.emit     = status.can_emit;
				cmd.emit_act = ACT_CURSOR;
				cmd.emit_val = VAL_LINE1;
				if (status.can_emit) cmd.idx_op = IDX_LINE1;
			end
			S_FLUSH: cmd.flush = status.out_free;
			default: ;
		endcase
	end

	`CDCB_ASSERT_IMP(a_idle_empty, clk, arst_n, state_q == S_IDLE, !status.pend_v, "held result left over after a byte")
	`CDCB_ASSERT_IMP(a_flush_has, clk, arst_n, state_q == S_FLUSH, status.pend_v, "final result missing at flush")
	`CDCB_ASSERT_IMP(a_copy_line1, clk, arst_n, cmd.wr_copy, status.pos_hi, "scroll copy while position on line 0")

endmodule

// ===== rtl/core/char_display_command_buffer.sv =====
// Top level of the two-line character display command buffer.
//
// Host bytes enter on in_valid/in_ready, display commands leave on
// out_valid/out_ready (action, value, last). One byte is handled at a time:
// a byte is taken in one cycle and executed in the next; a beep or a
// prefixed byte then passes a flush state that waits while the output is blocked.
// A line feed on line 1 scrolls through the single-port line store, one read
// and one write per entry. A show walks the store with a registered read per
// character and waits while out_ready is held low.
// The result output register lets a byte be taken while its last transfer waits.
// No clearing pass runs after reset; the power-up text is served from per-entry flags.
module char_display_command_buffer #(
	parameter int LINE_CHARS = cdcb_pkg::LINE_CHARS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] host_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] action,
	output logic [7:0] value,
	output logic       last
);
	import cdcb_pkg::*;

	cmd_t    cmd;
	status_t status;

	cdcb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	cdcb_datapath #(
		.LINE_CHARS (LINE_CHARS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.host_byte (host_byte),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.action    (action),
		.value     (value),
		.last      (last)
	);

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for char_display_command_buffer: directed and random host bytes.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cdcb_pkg::*;

	localparam int LINE_LEN    = LINE_CHARS_DEF;
	localparam int STORE_LEN   = 2 * LINE_LEN;
	localparam int IDLE_PCT    = 22;
	localparam int SETTLE_CYC  = 4 * LINE_LEN + 20;
	localparam int STALL_CYC   = 300;
	localparam int WDOG_LIMIT  = 2000;
	localparam int MAX_REPORTS = 10;

	// One display command as it leaves the block
	typedef struct packed {
		act_t       act;
		logic [7:0] val;
		logic       last;
	} disp_cmd_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic [7:0] host_byte = 8'h00;
	logic       out_ready = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic [1:0] action;
	logic [7:0] value;
	logic       last;

	// Predicted display state and commands still to come out
	disp_cmd_t   disp_cmds_due[$];
	logic [7:0]  line_img [STORE_LEN];
	int unsigned wr_pos;
	bit          cursor_armed;
	bit          direct_armed;

	int err_count    = 0;
	int idle_cyc     = 0;
	bit src_idle_en  = 1'b1;
	bit sink_idle_en = 1'b1;
	bit stall_tog    = 1'b0;
	bit stall_seen   = 1'b0;
	int stall_left   = 0;

	char_display_command_buffer #(
		.LINE_CHARS(LINE_LEN)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.host_byte(host_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.action   (action),
		.value    (value),
		.last     (last)
	);

	always #5 clk = ~clk;

	function automatic disp_cmd_t mk_cmd(input act_t a, input logic [7:0] v);
		disp_cmd_t c;
		c.act  = a;
		c.val  = v;
		c.last = 1'b0;
		return c;
	endfunction

	// Back to the start of the current line
	function automatic void carriage_home();
		wr_pos = (wr_pos < LINE_LEN) ? 0 : LINE_LEN;
	endfunction

	// Line 0: step down; line 1: scroll line 1 into line 0
	function automatic void line_feed_img();
		int i;
		if (wr_pos >= LINE_LEN) begin
			for (i = 0; i < LINE_LEN; i++) begin
				line_img[i]            = line_img[i + LINE_LEN];
				line_img[i + LINE_LEN] = 8'h00;
			end
		end else begin
			wr_pos = wr_pos + LINE_LEN;
		end
	endfunction

	// Update the display image for one host byte and queue the commands it causes
	function automatic void predict_display_cmds(input logic [7:0] b);
		disp_cmd_t res[$];
		disp_cmd_t c;
		int i;
		case (b)
			CODE_CLR_ALL: begin
				for (i = 0; i < STORE_LEN; i++) line_img[i] = 8'h00;
				wr_pos = 0;
			end
			CODE_CR:   carriage_home();
			CODE_LF:   line_feed_img();
			CODE_CRLF: begin
				carriage_home();
				line_feed_img();
			end
			CODE_BEEP: res.push_back(mk_cmd(ACT_BEEP, 8'h00));
			CODE_CLR0: begin
				for (i = 0; i < LINE_LEN; i++) line_img[i] = 8'h00;
				wr_pos = 0;
			end
			CODE_CLR1: begin
				for (i = LINE_LEN; i < STORE_LEN; i++) line_img[i] = 8'h00;
				wr_pos = LINE_LEN;
			end
			CODE_DIRECT: direct_armed = 1'b1;
			CODE_CURSOR: cursor_armed = 1'b1;
			CODE_SHOW: begin
				res.push_back(mk_cmd(ACT_CLEAR, 8'h00));
				res.push_back(mk_cmd(ACT_CURSOR, 8'h00));
				for (i = 0; i < LINE_LEN && line_img[i] != 8'h00; i++)
					res.push_back(mk_cmd(ACT_CHAR, line_img[i]));
				res.push_back(mk_cmd(ACT_CURSOR, LINE1_ADDR));
				for (i = LINE_LEN; i < STORE_LEN && line_img[i] != 8'h00; i++)
					res.push_back(mk_cmd(ACT_CHAR, line_img[i]));
			end
			default: begin
				// cursor prefix wins over direct prefix; the other stays armed
				if (cursor_armed) begin
					cursor_armed = 1'b0;
					res.push_back(mk_cmd(ACT_CURSOR, b));
				end else if (direct_armed) begin
					direct_armed = 1'b0;
					res.push_back(mk_cmd(ACT_CHAR, b));
				end else begin
					if (wr_pos >= STORE_LEN) wr_pos = LINE_LEN;
					line_img[wr_pos] = b;
					wr_pos++;
					// past the end wraps to line 1, not line 0
					if (wr_pos >= STORE_LEN) wr_pos = LINE_LEN;
				end
			end
		endcase
		if (res.size() > 0) begin
			c      = res.pop_back();
			c.last = 1'b1;
			res.push_back(c);
		end
		foreach (res[k]) disp_cmds_due.push_back(res[k]);
	endfunction

	function automatic logic [7:0] pick_ctrl_code();
		case ($urandom_range(0, 9))
			0:       return CODE_CLR_ALL;
			1:       return CODE_CR;
			2:       return CODE_LF;
			3:       return CODE_CRLF;
			4:       return CODE_BEEP;
			5:       return CODE_CLR0;
			6:       return CODE_CLR1;
			7:       return CODE_DIRECT;
			8:       return CODE_CURSOR;
			default: return CODE_SHOW;
		endcase
	endfunction

	// Random non-control byte
	function automatic logic [7:0] rand_plain(input bit allow_zero);
		logic [7:0] b;
		bit ctrl;
		do begin
			b = 8'($urandom_range(allow_zero ? 0 : 1, 255));
			case (b)
				CODE_CLR_ALL, CODE_CR, CODE_LF, CODE_CRLF, CODE_BEEP,
				CODE_CLR0, CODE_CLR1, CODE_DIRECT, CODE_CURSOR, CODE_SHOW: ctrl = 1'b1;
				default: ctrl = 1'b0;
			endcase
		end while (ctrl);
		return b;
	endfunction

	// One input transfer, with optional random gap before it
	task automatic send_byte(input logic [7:0] b);
		if (src_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
		end
		in_valid  <= 1'b1;
		host_byte <= b;
		do @(posedge clk); while (!in_ready);
		predict_display_cmds(b);
	endtask

	// Sender pause: wait for every command, then let the block settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (disp_cmds_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Mostly text and well-formed prefix pairs, some raw bytes and control codes
	task automatic send_random_item();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 40) begin
			send_byte(8'($urandom_range(8'h20, 8'h7E)));
		end else if (sel < 50) begin
			send_byte(8'($urandom_range(0, 255)));
		end else if (sel < 58) begin
			send_byte(CODE_SHOW);
		end else if (sel < 83) begin
			send_byte(pick_ctrl_code());
		end else begin
			send_byte($urandom_range(0, 1) ? CODE_CURSOR : CODE_DIRECT);
			if ($urandom_range(0, 3) != 0) send_byte(rand_plain(1'b1));
		end
	endtask

	task automatic test_power_up_banner();
		send_byte(CODE_SHOW);
	endtask

	task automatic test_control_codes();
		send_byte(8'h41);
		send_byte(CODE_CR);
		send_byte(CODE_LF);
		send_byte(8'h42);
		send_byte(CODE_LF);
		send_byte(CODE_SHOW);
		send_byte(CODE_CRLF);
		send_byte(8'h43);
		send_byte(CODE_CLR0);
		send_byte(8'h44);
		send_byte(CODE_CLR1);
		send_byte(8'h45);
		send_byte(CODE_BEEP);
		send_byte(CODE_SHOW);
		send_byte(CODE_CLR_ALL);
		send_byte(CODE_SHOW);
	endtask

	// Prefixes with extreme bytes, and prefixes kept across control codes
	task automatic test_prefix_codes();
		send_byte(CODE_CURSOR);
		send_byte(8'h00);
		send_byte(CODE_DIRECT);
		send_byte(8'hFF);
		send_byte(CODE_CURSOR);
		send_byte(CODE_BEEP);
		send_byte(CODE_DIRECT);
		send_byte(8'h41);
		send_byte(8'h42);
	endtask

	// Both lines full of random text, wrap at the end, largest show, scroll
	task automatic test_full_lines();
		int i;
		send_byte(CODE_CLR_ALL);
		for (i = 0; i <= STORE_LEN; i++) send_byte(rand_plain(1'b0));
		send_byte(CODE_SHOW);
		send_byte(CODE_LF);
		send_byte(CODE_SHOW);
	endtask

	task automatic test_random_traffic(input int n);
		int i;
		for (i = 0; i < n; i++) send_random_item();
	endtask

	task automatic test_no_idle_burst(input int n);
		int i;
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		for (i = 0; i < n; i++) send_random_item();
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
	endtask

	// Receiver holds off while the sender keeps offering
	task automatic test_output_backpressure();
		src_idle_en = 1'b0;
		stall_tog  <= ~stall_tog;
		send_byte(CODE_SHOW);
		send_byte(CODE_BEEP);
		send_byte(CODE_SHOW);
		send_byte(CODE_CURSOR);
		send_byte(8'h5A);
		send_byte(CODE_DIRECT);
		send_byte(8'h59);
		send_byte(CODE_SHOW);
		send_byte(CODE_BEEP);
		send_byte(8'h71);
		src_idle_en = 1'b1;
	endtask

	// Receiver ready: long hold on request, else random idling
	always @(posedge clk) begin : sink_ctrl
		if (stall_tog != stall_seen) begin
			stall_seen <= stall_tog;
			stall_left <= STALL_CYC;
			out_ready  <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else begin
			out_ready <= !(sink_idle_en && $urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Compare each output transfer with the oldest predicted command
	always @(posedge clk) begin : check_display_cmds
		disp_cmd_t want;
		if (out_valid && out_ready) begin
			if (disp_cmds_due.size() == 0) begin
				if (err_count < MAX_REPORTS)
					$display("%0t: unexpected command: action %0d value 0x%02h last %0d",
						$time, action, value, last);
				err_count++;
			end else begin
				want = disp_cmds_due.pop_front();
				if (action !== want.act || value !== want.val || last !== want.last) begin
					if (err_count < MAX_REPORTS)
						$display("%0t: expected action %0d value 0x%02h last %0d, got %0d 0x%02h %0d",
							$time, want.act, want.val, want.last, action, value, last);
					err_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin : watchdog
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cyc <= 0;
		end else if (idle_cyc >= WDOG_LIMIT) begin
			$display("[char_display_command_buffer] ERROR");
			$finish;
		end else begin
			idle_cyc <= idle_cyc + 1;
		end
	end

	initial begin : run_tests
		string banner;
		int i;
		// power-up image: banner text, zeros after it
		banner = "Waiting for data.";
		for (i = 0; i < STORE_LEN; i++)
			line_img[i] = (i < banner.len()) ? banner[i] : 8'h00;
		wr_pos       = 0;
		cursor_armed = 1'b0;
		direct_armed = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_up_banner();
		wait_drained();
		test_control_codes();
		wait_drained();
		test_prefix_codes();
		wait_drained();
		test_full_lines();
		wait_drained();
		test_random_traffic(120);
		wait_drained();
		test_full_lines();
		wait_drained();
		test_no_idle_burst(50);
		wait_drained();
		test_output_backpressure();
		wait_drained();
		test_random_traffic(40);
		wait_drained();

		if (err_count == 0 && disp_cmds_due.size() == 0) begin
			$display("[char_display_command_buffer] OK");
		end else begin
			$display("[char_display_command_buffer] ERROR");
		end
		$finish;
	end
endmodule
